// ===== rtl/pcfd_pkg.sv =====
package pcfd_pkg;

    localparam int VW     = 32;             // value width of fields and gains
    localparam int FB     = 16;             // fraction bits of the Q format
    localparam int IW     = 64;             // internal arithmetic width
    localparam int UW     = 24;             // elapsed time width
    localparam int CNT_W  = $clog2(2 * IW); // step counter of the serial unit
    localparam int RIDX_W = 3;              // register index width

    localparam logic signed [IW-1:0] IMAX = (IW'(1) <<< (IW - 2)) - IW'(1);
    localparam logic signed [IW-1:0] VMAX = (IW'(1) <<< (VW - 1)) - IW'(1);
    localparam logic signed [IW-1:0] VMIN = -VMAX - IW'(1);
    localparam logic signed [IW-1:0] QONE = IW'(1) <<< FB;
    localparam logic [IW-1:0] US_PER_S  = IW'(1000000);
    localparam logic [IW-1:0] SQ2_NUM   = IW'(707);
    localparam logic [IW-1:0] SQ2_DEN   = IW'(500);

    localparam logic [RIDX_W-1:0] REG_PROP_GAIN  = RIDX_W'(0);
    localparam logic [RIDX_W-1:0] REG_INTEG_GAIN = RIDX_W'(1);
    localparam logic [RIDX_W-1:0] REG_DERIV_GAIN = RIDX_W'(2);
    localparam logic [RIDX_W-1:0] REG_OUT_UPPER  = RIDX_W'(3);
    localparam logic [RIDX_W-1:0] REG_OUT_LOWER  = RIDX_W'(4);
    localparam logic [RIDX_W-1:0] REG_WINDUP     = RIDX_W'(5);
    localparam logic [RIDX_W-1:0] REG_WRAP       = RIDX_W'(6);
    localparam logic [RIDX_W-1:0] REG_FILTER_C   = RIDX_W'(7);

    localparam logic signed [VW-1:0] RST_PROP  = VW'(QONE);
    localparam logic signed [VW-1:0] RST_UPPER = VW'(QONE * 1000);
    localparam logic signed [VW-1:0] RST_LOWER = VW'(-(QONE * 1000));
    localparam logic [VW-2:0]        RST_BOUND = (VW-1)'(QONE * 1000);
    localparam logic [VW-2:0]        RST_C     = (VW-1)'(QONE);

    typedef struct packed {
        logic signed [VW-1:0] setpoint;
        logic signed [VW-1:0] measured;
        logic                 enable;
        logic [UW-1:0]        elapsed_us;
        logic                 setpoint_stale;
    } t_in_item;

    typedef struct packed {
        logic signed [VW-1:0] drive;
        logic signed [VW-1:0] prop_term;
        logic signed [VW-1:0] integ_term;
        logic signed [VW-1:0] deriv_term;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        logic signed [IW-1:0] a;
        logic signed [IW-1:0] b;
        logic [IW-1:0]        d;
    } t_md_req;

    typedef struct packed {
        logic                 done;
        logic signed [IW-1:0] res;
    } t_md_rsp;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_WRAPN,
        S_WRAPM,
        S_SAT,
        S_INTEG,
        S_SLOPE,
        S_C2,
        S_K,
        S_A2,
        S_A1,
        S_Y,
        S_P,
        S_I,
        S_D,
        S_EMIT
    } t_state;

    function automatic logic signed [IW-1:0] f_sx(input logic signed [VW-1:0] v);
        return {{(IW - VW){v[VW-1]}}, v};
    endfunction

    // clamp to the value range and narrow
    function automatic logic signed [VW-1:0] f_satv(input logic signed [IW-1:0] x);
        logic signed [IW-1:0] c;
        c = x;
        if (x > VMAX) begin
            c = VMAX;
        end else if (x < VMIN) begin
            c = VMIN;
        end
        return c[VW-1:0];
    endfunction

    // add with saturation at +-IMAX
    function automatic logic signed [IW-1:0] f_sadd(input logic signed [IW-1:0] a,
                                                    input logic signed [IW-1:0] b);
        logic signed [IW:0] s;
        logic signed [IW:0] hi;
        s  = {a[IW-1], a} + {b[IW-1], b};
        hi = {IMAX[IW-1], IMAX};
        if (s > hi) begin
            return IMAX;
        end else if (s < -hi) begin
            return -IMAX;
        end
        return s[IW-1:0];
    endfunction

endpackage

// ===== rtl/pcfd_muldiv.sv =====
module pcfd_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcfd_pkg::t_md_req i_req,
    output pcfd_pkg::t_md_rsp o_rsp
);
    import pcfd_pkg::*;

    // a*b/d truncated toward zero, magnitude capped at IMAX.
    // One product bit per cycle, then one quotient bit per cycle.
    t_md_phase         r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IW-1:0]     r_mcand, n_mcand;
    logic [IW-1:0]     r_plier, n_plier;
    logic [IW:0]       r_hi, n_hi;
    logic [IW-1:0]     r_lo, n_lo;
    logic [IW-1:0]     r_d, n_d;
    logic [IW-1:0]     r_rem, n_rem;
    logic [IW-1:0]     r_q, n_q;
    logic              r_ovf, n_ovf;
    logic              r_neg, n_neg;
    logic              r_done, n_done;
    logic [IW:0]       sum;
    logic [IW-1:0]     rem_sh;
    logic [IW-1:0]     mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MD_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_mcand <= n_mcand;
        r_plier <= n_plier;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_d     <= n_d;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_ovf   <= n_ovf;
        r_neg   <= n_neg;
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_mcand = r_mcand;
        n_plier = r_plier;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_d     = r_d;
        n_rem   = r_rem;
        n_q     = r_q;
        n_ovf   = r_ovf;
        n_neg   = r_neg;
        n_done  = 1'b0;
        sum     = r_hi + {1'b0, (r_plier[0] ? r_mcand : '0)};
        rem_sh  = {r_rem[IW-2:0], r_hi[IW-1]};
        case (r_phase)
            MD_IDLE: begin
                if (i_req.start) begin
                    n_mcand = i_req.a[IW-1] ? IW'(-i_req.a) : IW'(i_req.a);
                    n_plier = i_req.b[IW-1] ? IW'(-i_req.b) : IW'(i_req.b);
                    n_d     = i_req.d;
                    n_neg   = i_req.a[IW-1] ^ i_req.b[IW-1];
                    n_hi    = '0;
                    n_lo    = '0;
                    n_cnt   = '0;
                    n_phase = MD_MUL;
                end
            end
            MD_MUL: begin
                n_hi    = {1'b0, sum[IW:1]};
                n_lo    = {sum[0], r_lo[IW-1:1]};
                n_plier = r_plier >> 1;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(IW - 1)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_q     = '0;
                    n_ovf   = 1'b0;
                    n_phase = MD_DIV;
                end
            end
            MD_DIV: begin
                if (rem_sh >= r_d) begin
                    n_rem = rem_sh - r_d;
                    n_q   = {r_q[IW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_q   = {r_q[IW-2:0], 1'b0};
                end
                n_ovf = r_ovf | r_q[IW-1];
                n_hi  = {1'b0, r_hi[IW-2:0], r_lo[IW-1]};
                n_lo  = {r_lo[IW-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(2 * IW - 1)) begin
                    n_cnt   = '0;
                    n_done  = 1'b1;
                    n_phase = MD_IDLE;
                end
            end
            default: begin
                n_phase = MD_IDLE;
            end
        endcase
    end

    assign mag       = (r_ovf | r_q[IW-1] | r_q[IW-2]) ? IMAX : r_q;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_neg ? -$signed(mag) : $signed(mag);

endmodule

// ===== rtl/pid_controller_filtered_derivative.sv =====
// Channel  | Handshake                     | Payload
// -------- | ----------------------------- | ---------------------------
// input    | i_in_valid / o_in_stall       | i_in_data  (t_in_item)
// output   | o_out_valid / i_out_stall     | o_out_data (t_out_item)
// config   | i_cfg_we                      | i_cfg_idx, i_cfg_data
//
// One sample at a time. A full sample runs up to 12 operations on the shared
// bit-serial multiply-divide unit, each 64 + 128 steps; a disabled sample uses
// none of them, and a priming one stops before the integral.
// Reset (synchronous, active low) restores the register defaults and clears
// the loop history. The result sits in an output register; a new sample is
// taken while it waits, and only the final hand-off waits on i_out_stall.
module pid_controller_filtered_derivative (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pcfd_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pcfd_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_we,
    input  logic [pcfd_pkg::RIDX_W-1:0]   i_cfg_idx,
    input  logic [pcfd_pkg::VW-1:0]       i_cfg_data
);
    import pcfd_pkg::*;

    t_state               r_state, n_state;
    t_in_item             r_item, n_item;
    // configuration registers
    logic signed [VW-1:0] r_kp, n_kp, r_ki, n_ki, r_kd, n_kd;
    logic signed [VW-1:0] r_upper, n_upper, r_lower, n_lower;
    logic [VW-2:0]        r_bound, n_bound, r_wrap, n_wrap, r_c, n_c;
    // loop history
    logic signed [VW-1:0] r_prior, n_prior, r_sum, n_sum;
    logic signed [VW-1:0] r_raw [3];
    logic signed [VW-1:0] n_raw [3];
    logic signed [VW-1:0] r_sm [3];
    logic signed [VW-1:0] n_sm [3];
    logic                 r_primed, n_primed;
    // per-sample working values
    logic signed [IW-1:0] r_e, n_e, r_eold, n_eold;
    logic                 r_wneg, n_wneg;
    logic signed [IW-1:0] r_c2, n_c2, r_den, n_den, r_a1, n_a1, r_num, n_num;
    logic signed [VW-1:0] r_y, n_y, r_p, n_p, r_it, n_it, r_dt, n_dt;
    logic signed [VW-1:0] r_drive, n_drive;
    // result register
    t_out_item            r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    t_md_req              md_req;
    t_md_rsp              md_rsp;

    pcfd_muldiv u_muldiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (md_req),
        .o_rsp  (md_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kp        <= RST_PROP;
            r_ki        <= '0;
            r_kd        <= '0;
            r_upper     <= RST_UPPER;
            r_lower     <= RST_LOWER;
            r_bound     <= RST_BOUND;
            r_wrap      <= '0;
            r_c         <= RST_C;
            r_prior     <= '0;
            r_sum       <= '0;
            r_primed    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_raw[i] <= '0;
                r_sm[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_kp        <= n_kp;
            r_ki        <= n_ki;
            r_kd        <= n_kd;
            r_upper     <= n_upper;
            r_lower     <= n_lower;
            r_bound     <= n_bound;
            r_wrap      <= n_wrap;
            r_c         <= n_c;
            r_prior     <= n_prior;
            r_sum       <= n_sum;
            r_primed    <= n_primed;
            for (int i = 0; i < 3; i++) begin
                r_raw[i] <= n_raw[i];
                r_sm[i]  <= n_sm[i];
            end
        end
        r_item  <= n_item;
        r_e     <= n_e;
        r_eold  <= n_eold;
        r_wneg  <= n_wneg;
        r_c2    <= n_c2;
        r_den   <= n_den;
        r_a1    <= n_a1;
        r_num   <= n_num;
        r_y     <= n_y;
        r_p     <= n_p;
        r_it    <= n_it;
        r_dt    <= n_dt;
        r_drive <= n_drive;
        r_out   <= n_out;
    end

    always_comb begin
        logic signed [IW-1:0] e;
        logic signed [IW-1:0] t;
        logic signed [IW-1:0] wrap;
        logic signed [IW-1:0] bnd;
        logic signed [IW-1:0] s;
        logic signed [IW-1:0] k;
        logic signed [IW-1:0] a2;
        logic signed [IW-1:0] eff;
        logic signed [VW-1:0] es;
        logic signed [VW-1:0] v;

        n_state     = r_state;
        n_item      = r_item;
        n_kp        = r_kp;
        n_ki        = r_ki;
        n_kd        = r_kd;
        n_upper     = r_upper;
        n_lower     = r_lower;
        n_bound     = r_bound;
        n_wrap      = r_wrap;
        n_c         = r_c;
        n_prior     = r_prior;
        n_sum       = r_sum;
        n_primed    = r_primed;
        n_raw       = r_raw;
        n_sm        = r_sm;
        n_e         = r_e;
        n_eold      = r_eold;
        n_wneg      = r_wneg;
        n_c2        = r_c2;
        n_den       = r_den;
        n_a1        = r_a1;
        n_num       = r_num;
        n_y         = r_y;
        n_p         = r_p;
        n_it        = r_it;
        n_dt        = r_dt;
        n_drive     = r_drive;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        md_req      = '0;

        wrap = IW'(r_wrap);
        bnd  = IW'(r_bound);
        e    = f_sx(r_item.setpoint) - f_sx(r_item.measured);
        t    = e <<< 1;
        es   = f_satv(r_e);
        s    = '0;
        k    = '0;
        a2   = '0;
        eff  = '0;
        v    = '0;

        // configuration writes, taken whenever offered
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN:  n_kp    = i_cfg_data;
                REG_INTEG_GAIN: n_ki    = i_cfg_data;
                REG_DERIV_GAIN: n_kd    = i_cfg_data;
                REG_OUT_UPPER:  n_upper = i_cfg_data;
                REG_OUT_LOWER:  n_lower = i_cfg_data;
                REG_WINDUP:     n_bound = i_cfg_data[VW-2:0];
                REG_WRAP:       n_wrap  = i_cfg_data[VW-2:0];
                REG_FILTER_C:   n_c     = i_cfg_data[VW-2:0];
                default: ;
            endcase
        end

        // drop the result once the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    if (!i_in_data.enable) begin
                        // disabled: clear the integral, emit all zeros
                        n_sum   = '0;
                        n_drive = '0;
                        n_p     = '0;
                        n_it    = '0;
                        n_dt    = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_ERR: begin
                n_e = e;
                if (wrap != '0 && t > wrap) begin
                    md_req.start = 1'b1;
                    md_req.a     = t + wrap - IW'(1);
                    md_req.b     = IW'(1);
                    md_req.d     = wrap << 1;
                    n_wneg       = 1'b0;
                    n_state      = S_WRAPN;
                end else if (wrap != '0 && t < -wrap) begin
                    md_req.start = 1'b1;
                    md_req.a     = -t + wrap - IW'(1);
                    md_req.b     = IW'(1);
                    md_req.d     = wrap << 1;
                    n_wneg       = 1'b1;
                    n_state      = S_WRAPN;
                end else begin
                    n_state = S_SAT;
                end
            end
            S_WRAPN: begin
                // wrap count known: if nonzero, clear the integral and raw slopes, then form count * period
                if (md_rsp.done) begin
                    if (md_rsp.res != '0) begin
                        n_sum = '0;
                        for (int i = 0; i < 3; i++) begin
                            n_raw[i] = '0;
                        end
                    end
                    md_req.start = 1'b1;
                    md_req.a     = md_rsp.res;
                    md_req.b     = wrap;
                    md_req.d     = IW'(1);
                    n_state      = S_WRAPM;
                end
            end
            S_WRAPM: begin
                if (md_rsp.done) begin
                    n_e     = r_wneg ? r_e + md_rsp.res : r_e - md_rsp.res;
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_e     = f_sx(es);
                n_eold  = f_sx(r_prior);
                n_prior = es;
                if (!r_primed) begin
                    n_primed = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_item.elapsed_us == '0) begin
                    n_state = S_IDLE;
                end else begin
                    md_req.start = 1'b1;
                    md_req.a     = f_sx(es);
                    md_req.b     = IW'(r_item.elapsed_us);
                    md_req.d     = US_PER_S;
                    n_state      = S_INTEG;
                end
            end
            S_INTEG: begin
                // integrate with the windup clamp, then start the raw slope
                if (md_rsp.done) begin
                    s = f_sadd(f_sx(r_sum), md_rsp.res);
                    if (s > bnd) begin
                        s = bnd;
                    end else if (s < -bnd) begin
                        s = -bnd;
                    end
                    n_sum        = s[VW-1:0];
                    md_req.start = 1'b1;
                    md_req.a     = r_e - r_eold;
                    md_req.b     = $signed(US_PER_S);
                    md_req.d     = IW'(r_item.elapsed_us);
                    n_state      = S_SLOPE;
                end
            end
            S_SLOPE: begin
                if (md_rsp.done) begin
                    n_raw[0]     = f_satv(md_rsp.res);
                    n_raw[1]     = r_raw[0];
                    n_raw[2]     = r_raw[1];
                    md_req.start = 1'b1;
                    md_req.a     = IW'(r_c);
                    md_req.b     = IW'(r_c);
                    md_req.d     = QONE;
                    n_state      = S_C2;
                end
            end
            S_C2: begin
                if (md_rsp.done) begin
                    n_c2         = md_rsp.res;
                    md_req.start = 1'b1;
                    md_req.a     = IW'(r_c);
                    md_req.b     = $signed(SQ2_NUM);
                    md_req.d     = SQ2_DEN;
                    n_state      = S_K;
                end
            end
            S_K: begin
                // filter coefficients and the feed-forward sum
                if (md_rsp.done) begin
                    k            = md_rsp.res;
                    n_den        = f_sadd(f_sadd(QONE, r_c2), k);
                    a2           = f_sadd(f_sadd(r_c2, -k), QONE);
                    n_a1         = f_sadd(QONE <<< 1, f_sadd(-r_c2, -r_c2));
                    n_num        = f_sx(r_raw[2]) + (f_sx(r_raw[1]) <<< 1) + f_sx(r_raw[0]);
                    md_req.start = 1'b1;
                    md_req.a     = a2;
                    md_req.b     = f_sx(r_sm[1]);
                    md_req.d     = QONE;
                    n_state      = S_A2;
                end
            end
            S_A2: begin
                if (md_rsp.done) begin
                    n_num        = f_sadd(r_num, -md_rsp.res);
                    md_req.start = 1'b1;
                    md_req.a     = r_a1;
                    md_req.b     = f_sx(r_sm[0]);
                    md_req.d     = QONE;
                    n_state      = S_A1;
                end
            end
            S_A1: begin
                if (md_rsp.done) begin
                    md_req.start = 1'b1;
                    md_req.a     = f_sadd(r_num, -md_rsp.res);
                    md_req.b     = QONE;
                    md_req.d     = r_den;
                    n_state      = S_Y;
                end
            end
            S_Y: begin
                if (md_rsp.done) begin
                    v            = f_satv(md_rsp.res);
                    n_y          = v;
                    n_sm[0]      = v;
                    n_sm[1]      = r_sm[0];
                    n_sm[2]      = r_sm[1];
                    md_req.start = 1'b1;
                    md_req.a     = f_sx(r_kp);
                    md_req.b     = r_e;
                    md_req.d     = QONE;
                    n_state      = S_P;
                end
            end
            S_P: begin
                if (md_rsp.done) begin
                    n_p          = f_satv(md_rsp.res);
                    md_req.start = 1'b1;
                    md_req.a     = f_sx(r_ki);
                    md_req.b     = f_sx(r_sum);
                    md_req.d     = QONE;
                    n_state      = S_I;
                end
            end
            S_I: begin
                if (md_rsp.done) begin
                    n_it         = f_satv(md_rsp.res);
                    md_req.start = 1'b1;
                    md_req.a     = f_sx(r_kd);
                    md_req.b     = f_sx(r_y);
                    md_req.d     = QONE;
                    n_state      = S_D;
                end
            end
            S_D: begin
                // sum the terms and clamp, upper limit first
                if (md_rsp.done) begin
                    v    = f_satv(md_rsp.res);
                    n_dt = v;
                    eff  = f_sx(r_p) + f_sx(r_it) + f_sx(v);
                    if (eff > f_sx(r_upper)) begin
                        eff = f_sx(r_upper);
                    end else if (eff < f_sx(r_lower)) begin
                        eff = f_sx(r_lower);
                    end
                    n_drive = eff[VW-1:0];
                    if (r_item.setpoint_stale) begin
                        n_sum   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out.drive      = r_drive;
                    n_out.prop_term  = r_p;
                    n_out.integ_term = r_it;
                    n_out.deriv_term = r_dt;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_primed_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("primed flag fell without reset");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state != S_IDLE && r_state != S_EMIT && r_state != S_ERR
                         && r_state != S_SAT))
        else $error("multiply-divide finished outside a wait state");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result raised outside the emit state");
`endif

endmodule

// ===== test/pcfd_checker.sv =====
module pcfd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  pcfd_pkg::t_in_item            i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  pcfd_pkg::t_out_item           i_out_data,
    input  logic                          i_cfg_we,
    input  logic [pcfd_pkg::RIDX_W-1:0]   i_cfg_idx,
    input  logic [pcfd_pkg::VW-1:0]       i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import pcfd_pkg::*;

    localparam longint LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint ONE = 64'sd65536;
    localparam longint V_HI = 64'sd2147483647;
    localparam longint V_LO = -64'sd2147483648;

    logic [VW-1:0] cfg_reg [8];
    longint prior_err, err_accum;
    longint raw_hist [3];
    longint smooth_hist [3];
    bit     loop_primed;
    t_out_item drive_queue [$];

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint sat_value(longint x);
        return clip(x, V_LO, V_HI);
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        return clip(a + b, -LIM, LIM);
    endfunction

    // exact a*b/d, truncated toward zero, magnitude capped
    function automatic longint scaled_product(longint a, longint b, longint d);
        logic [127:0] prod;
        logic [127:0] quo;
        logic [63:0]  ua;
        logic [63:0]  ub;
        bit           neg;
        neg  = (a < 0) != (b < 0);
        ua   = a < 0 ? -a : a;
        ub   = b < 0 ? -b : b;
        prod = {64'd0, ua} * {64'd0, ub};
        quo  = prod / {64'd0, d};
        if (quo > 128'(LIM)) quo = 128'(LIM);
        return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return scaled_product(a, b, ONE);
    endfunction

    function automatic longint reg_s(int i);
        return longint'(signed'(cfg_reg[i]));
    endfunction

    function automatic longint reg_u(int i);
        return longint'({33'd0, cfg_reg[i][VW-2:0]});
    endfunction

    // advance the loop by one sample; queue a drive result when one is due
    task automatic predict_sample(input t_in_item it);
        longint e, e_old, wrap, t, n, bound, slope, c, c2, k, den, a1, a2, num, y0;
        longint p, ip, dp, eff, us;
        t_out_item r;
        if (!it.enable) begin
            err_accum = 0;
            drive_queue.push_back('0);
            return;
        end
        wrap = reg_u(REG_WRAP);
        e = longint'(it.setpoint) - longint'(it.measured);
        if (wrap > 0) begin
            t = 2 * e;
            n = 0;
            if (t > wrap) begin
                n = (t + wrap - 1) / (2 * wrap);
                e -= n * wrap;
            end else if (t < -wrap) begin
                n = (-t + wrap - 1) / (2 * wrap);
                e += n * wrap;
            end
            if (n > 0) begin
                raw_hist = '{0, 0, 0};
                err_accum = 0;
            end
        end
        e = sat_value(e);
        e_old = prior_err;
        prior_err = e;
        if (!loop_primed) begin
            loop_primed = 1;
            return;
        end
        us = longint'(it.elapsed_us);
        if (us == 0) return;

        bound = reg_u(REG_WINDUP);
        err_accum = clip(sat_sum(err_accum, scaled_product(e, us, 1000000)), -bound, bound);
        slope = sat_value(scaled_product(e - e_old, 1000000, us));
        raw_hist[2] = raw_hist[1];
        raw_hist[1] = raw_hist[0];
        raw_hist[0] = slope;

        // second-order low-pass on the raw slope
        c   = reg_u(REG_FILTER_C);
        c2  = q_mul(c, c);
        k   = scaled_product(c, 707, 500);
        den = sat_sum(sat_sum(ONE, c2), k);
        a2  = sat_sum(sat_sum(c2, -k), ONE);
        a1  = sat_sum(2 * ONE, sat_sum(-c2, -c2));
        num = raw_hist[2] + 2 * raw_hist[1] + raw_hist[0];
        num = sat_sum(num, -q_mul(a2, smooth_hist[1]));
        num = sat_sum(num, -q_mul(a1, smooth_hist[0]));
        y0  = sat_value(scaled_product(num, ONE, den));
        smooth_hist[2] = smooth_hist[1];
        smooth_hist[1] = smooth_hist[0];
        smooth_hist[0] = y0;

        p   = sat_value(q_mul(reg_s(REG_PROP_GAIN), e));
        ip  = sat_value(q_mul(reg_s(REG_INTEG_GAIN), err_accum));
        dp  = sat_value(q_mul(reg_s(REG_DERIV_GAIN), y0));
        eff = p + ip + dp;
        if (eff > reg_s(REG_OUT_UPPER)) eff = reg_s(REG_OUT_UPPER);
        else if (eff < reg_s(REG_OUT_LOWER)) eff = reg_s(REG_OUT_LOWER);
        if (it.setpoint_stale) begin
            err_accum = 0;
            return;
        end
        r.drive      = eff[VW-1:0];
        r.prop_term  = p[VW-1:0];
        r.integ_term = ip[VW-1:0];
        r.deriv_term = dp[VW-1:0];
        drive_queue.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_reg[REG_PROP_GAIN]  = RST_PROP;
            cfg_reg[REG_INTEG_GAIN] = '0;
            cfg_reg[REG_DERIV_GAIN] = '0;
            cfg_reg[REG_OUT_UPPER]  = RST_UPPER;
            cfg_reg[REG_OUT_LOWER]  = RST_LOWER;
            cfg_reg[REG_WINDUP]     = {1'b0, RST_BOUND};
            cfg_reg[REG_WRAP]       = '0;
            cfg_reg[REG_FILTER_C]   = {1'b0, RST_C};
            prior_err   = 0;
            err_accum   = 0;
            raw_hist    = '{0, 0, 0};
            smooth_hist = '{0, 0, 0};
            loop_primed = 0;
        end else begin
            if (i_cfg_we) begin
                cfg_reg[i_cfg_idx] = i_cfg_data;
                if (i_cfg_idx >= REG_WINDUP) cfg_reg[i_cfg_idx][VW-1] = 1'b0;
            end
            if (i_out_valid && !i_out_stall) begin
                if (drive_queue.size() == 0) begin
                    $error("unexpected drive result %h", i_out_data);
                    o_fail_count++;
                end else begin
                    want = drive_queue.pop_front();
                    if (i_out_data.drive !== want.drive) begin
                        $error("drive: expected %h, got %h", want.drive, i_out_data.drive);
                        o_fail_count++;
                    end
                    if (i_out_data.prop_term !== want.prop_term) begin
                        $error("prop_term: expected %h, got %h",
                               want.prop_term, i_out_data.prop_term);
                        o_fail_count++;
                    end
                    if (i_out_data.integ_term !== want.integ_term) begin
                        $error("integ_term: expected %h, got %h",
                               want.integ_term, i_out_data.integ_term);
                        o_fail_count++;
                    end
                    if (i_out_data.deriv_term !== want.deriv_term) begin
                        $error("deriv_term: expected %h, got %h",
                               want.deriv_term, i_out_data.deriv_term);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_sample(i_in_data);
        end
        o_pending = drive_queue.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

// ===== test/pid_controller_filtered_derivative_tb.sv =====
module pid_controller_filtered_derivative_tb;
    import pcfd_pkg::*;

    // SETTLE leaves room for a full sample inside the block
    localparam int SETTLE    = 3000;
    localparam int WATCH_MAX = 40000;
    localparam int HOLD_LEN  = 8000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_item            in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_item           out_data;
    logic                cfg_we = 1'b0;
    logic [RIDX_W-1:0]   cfg_idx = '0;
    logic [VW-1:0]       cfg_data = '0;
    int                  fail_count;
    int                  pending;

    bit no_idle   = 1'b0;   // suppress random gaps on both sides
    bit hold_out  = 1'b0;   // long receiver hold-off
    int sent      = 0;
    int quiet     = 0;

    always #1 i_clk = ~i_clk;

    pid_controller_filtered_derivative dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pcfd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: stall at random, or solidly during the hold-off.
    always @(posedge i_clk) begin
        out_stall <= hold_out || (!no_idle && $urandom_range(99) < 36);
    end

    // Hold the output for a long stretch once traffic is flowing, so the block
    // fills and pushes back on its input.
    initial begin
        wait (sent >= 40);
        @(posedge i_clk);
        hold_out = 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_out = 1'b0;
    end

    // Watchdog: count cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCH_MAX) begin
            $display("pid_controller_filtered_derivative_tb: errors");
            $finish;
        end
    end

    // Offer one transaction; keep valid high straight into the next one
    // unless a random gap is drawn.
    task automatic send_sample(input t_in_item it);
        while (!no_idle && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!(in_valid && !in_stall));
        sent++;
    endtask

    task automatic send_fields(input logic [VW-1:0] sp, input logic [VW-1:0] ms,
                               input logic en, input logic [UW-1:0] us, input logic st);
        t_in_item it;
        it.setpoint = sp;
        it.measured = ms;
        it.enable = en;
        it.elapsed_us = us;
        it.setpoint_stale = st;
        send_sample(it);
    endtask

    task automatic write_reg(input logic [RIDX_W-1:0] idx, input logic [VW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain the block: all results in, then room for a sample that yields none.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [VW-1:0] pick_gain();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            default: return VW'(int'($urandom_range(524288)) - 262144);
        endcase
    endfunction

    task automatic random_config();
        logic [VW-1:0] up, lo;
        write_reg(REG_PROP_GAIN, pick_gain());
        write_reg(REG_INTEG_GAIN, pick_gain());
        write_reg(REG_DERIV_GAIN, pick_gain());
        up = $urandom_range(7) == 0 ? 32'h7FFF_FFFF : VW'($urandom_range(65536000, 1));
        lo = $urandom_range(7) == 0 ? 32'h8000_0000 : VW'(-int'($urandom_range(65536000)));
        if ($urandom_range(9) == 0) lo = up + 32'd65536;   // crossed limits
        write_reg(REG_OUT_UPPER, up);
        write_reg(REG_OUT_LOWER, lo);
        case ($urandom_range(4))
            0:       write_reg(REG_WINDUP, 32'h7FFF_FFFF);
            1:       write_reg(REG_WINDUP, 32'h0);
            default: write_reg(REG_WINDUP, VW'($urandom_range(65536000)));
        endcase
        case ($urandom_range(3))
            0:       write_reg(REG_WRAP, VW'(411775));   // one turn in radians
            1:       write_reg(REG_WRAP, $urandom_range(3) == 0 ? 32'h7FFF_FFFF
                                                             : VW'($urandom_range(2000000, 1)));
            default: write_reg(REG_WRAP, 32'h0);
        endcase
        case ($urandom_range(5))
            0:       write_reg(REG_FILTER_C, 32'h7FFF_FFFF);
            1:       write_reg(REG_FILTER_C, VW'(655));
            2:       write_reg(REG_FILTER_C, 32'h0);
            default: write_reg(REG_FILTER_C, VW'($urandom_range(1310720, 655)));
        endcase
    endtask

    task automatic random_sample();
        logic [VW-1:0] sp, ms;
        logic [UW-1:0] us;
        if ($urandom_range(9) == 0) begin
            sp = $urandom;
            ms = $urandom;
        end else begin
            sp = VW'(int'($urandom_range(1310720)) - 655360);
            ms = VW'(int'($urandom_range(1310720)) - 655360);
        end
        case ($urandom_range(19))
            0:       us = '0;
            1:       us = UW'($urandom);
            2:       us = 24'hFF_FFFF;
            default: us = UW'($urandom_range(20000, 1));
        endcase
        send_fields(sp, ms, $urandom_range(19) != 0, us, $urandom_range(14) == 0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults first; priming, normal, zero interval, extremes, stale, disabled.
        send_fields(32'h0001_0000, 32'h0, 1'b1, 24'd1000, 1'b0);
        send_fields(32'h0001_0000, 32'h0, 1'b1, 24'd1000, 1'b0);
        send_fields(32'h0002_0000, 32'h0, 1'b1, 24'd0, 1'b0);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 24'hFF_FFFF, 1'b0);
        send_fields(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 24'd1, 1'b0);
        send_fields(32'h0003_0000, 32'h0001_0000, 1'b1, 24'd500, 1'b1);
        send_fields(32'h0003_0000, 32'h0001_0000, 1'b0, 24'd500, 1'b0);
        send_fields(32'h0003_0000, 32'h0001_0000, 1'b1, 24'd500, 1'b0);
        drain();

        // Directed: wrapping, full filter path, crossed limits, zero c.
        write_reg(REG_INTEG_GAIN, 32'h0002_0000);
        write_reg(REG_DERIV_GAIN, 32'h0000_8000);
        write_reg(REG_WRAP, VW'(411775));
        write_reg(REG_OUT_UPPER, 32'h0010_0000);
        write_reg(REG_OUT_LOWER, 32'h0020_0000);
        write_reg(REG_WINDUP, 32'h7FFF_FFFF);
        write_reg(REG_FILTER_C, 32'h0);
        send_fields(32'h0005_0000, 32'h0, 1'b1, 24'd2000, 1'b0);
        send_fields(32'hFFFA_0000, 32'h0, 1'b1, 24'd2000, 1'b0);
        send_fields(32'h0001_0000, 32'h0, 1'b1, 24'd2000, 1'b0);
        send_fields(32'h0003_0000, 32'h0, 1'b1, 24'd2000, 1'b0);
        send_fields(32'h7FFF_FFFF, 32'h0, 1'b1, 24'd2000, 1'b0);
        send_fields(32'h0, 32'h0, 1'b1, 24'd2000, 1'b0);
        drain();
        write_reg(REG_FILTER_C, 32'h7FFF_FFFF);
        write_reg(REG_OUT_LOWER, 32'h8000_0000);
        write_reg(REG_OUT_UPPER, 32'h7FFF_FFFF);
        send_fields(32'h0004_0000, 32'h0, 1'b1, 24'd100, 1'b0);
        send_fields(32'hFFFC_0000, 32'h0, 1'b1, 24'd100, 1'b0);
        send_fields(32'h0, 32'h0004_0000, 1'b1, 24'd100, 1'b0);
        drain();

        // Random phases with fresh settings; one phase runs without gaps.
        for (int ph = 0; ph < 8; ph++) begin
            random_config();
            no_idle = (ph == 3);
            for (int n = 0; n < 116; n++) random_sample();
            no_idle = 1'b0;
            drain();
        end

        if (fail_count == 0) begin
            $display("pid_controller_filtered_derivative_tb: clean");
        end else begin
            $display("pid_controller_filtered_derivative_tb: errors");
        end
        $finish;
    end

endmodule
